@@ sv/smx_pkg.sv @@
// Shared constants, types and helpers of the SplitMix64 range draw core.
package smx_pkg;

	localparam int SMX_W         = 64;  // generator word
	localparam int SMX_D_W       = 63;  // bounds, results, masked draw
	localparam int SMX_HALF_W    = 32;  // multiplier operand width
	localparam int SMX_FOLD_SH   = 33;
	localparam int SMX_FRAC_SH   = 11;
	localparam int SMX_MAX_TRIES = 256;

	localparam logic [SMX_W-1:0] SMX_MIX_C1      = 64'hff51afd7ed558ccd;
	localparam logic [SMX_W-1:0] SMX_MIX_C2      = 64'hc4ceb9fe1a85ec53;
	localparam logic [SMX_W-1:0] SMX_GAMMA_RESET = 64'h9e3779b97f4a7c15;

	// request kinds
	localparam logic [1:0] KIND_BIT  = 2'd0;
	localparam logic [1:0] KIND_INT  = 2'd1;
	localparam logic [1:0] KIND_FRAC = 2'd2;

	// configuration register indexes
	localparam logic REG_START_SEED = 1'b0;
	localparam logic REG_GAMMA      = 1'b1;

	// multiplier steps: low x low, low x high, high x low
	localparam logic [1:0] MUL_LL = 2'd0;
	localparam logic [1:0] MUL_LH = 2'd1;
	localparam logic [1:0] MUL_HL = 2'd2;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_CHECK   = 11'b000_0000_0010,
		ST_ADV     = 11'b000_0000_0100,
		ST_M1GO    = 11'b000_0000_1000,
		ST_M1WAIT  = 11'b000_0001_0000,
		ST_M2GO    = 11'b000_0010_0000,
		ST_M2WAIT  = 11'b000_0100_0000,
		ST_DIVGO   = 11'b000_1000_0000,
		ST_DIVWAIT = 11'b001_0000_0000,
		ST_JUDGE   = 11'b010_0000_0000,
		ST_DONE    = 11'b100_0000_0000
	} smx_state_t;

	function automatic logic [SMX_W-1:0] smx_fold(input logic [SMX_W-1:0] x);
		return x ^ (x >> SMX_FOLD_SH);
	endfunction

endpackage

@@ sv/smx_mul.sv @@
// Iterative 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle.
module smx_mul import smx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SMX_W-1:0] a,
	input  logic [SMX_W-1:0] b,
	output logic             done,
	output logic [SMX_W-1:0] p
);

	logic [SMX_W-1:0]      a_q;
	logic [SMX_W-1:0]      b_q;
	logic [SMX_W-1:0]      acc_q;
	logic [1:0]            step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SMX_HALF_W-1:0] x;
	logic [SMX_HALF_W-1:0] y;
	logic [SMX_W-1:0]      prod;

	always_comb begin
		case (step_q)
			MUL_LL: begin
				x = a_q[SMX_HALF_W-1:0];
				y = b_q[SMX_HALF_W-1:0];
			end
			MUL_LH: begin
				x = a_q[SMX_HALF_W-1:0];
				y = b_q[SMX_W-1:SMX_HALF_W];
			end
			default: begin
				x = a_q[SMX_W-1:SMX_HALF_W];
				y = b_q[SMX_HALF_W-1:0];
			end
		endcase
		prod = {{(SMX_W-SMX_HALF_W){1'b0}}, x} * {{(SMX_W-SMX_HALF_W){1'b0}}, y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= MUL_LL;
		end else begin
			done_q <= busy_q && (step_q == MUL_HL);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= MUL_LL;
			end else if (busy_q) begin
				if (step_q == MUL_HL) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	// cross terms only contribute their low half, shifted up
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (step_q == MUL_LL) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[SMX_HALF_W-1:0], {SMX_HALF_W{1'b0}}};
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

@@ sv/smx_div.sv @@
// Restoring remainder unit, one dividend bit per cycle.
module smx_div import smx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SMX_D_W-1:0] dividend,
	input  logic [SMX_W-1:0]   divisor,
	output logic               done,
	output logic [SMX_D_W-1:0] rem
);

	localparam int CntW = $clog2(SMX_D_W);

	logic [SMX_D_W-1:0] num_q;
	logic [SMX_D_W-1:0] rem_q;
	logic [SMX_W-1:0]   div_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SMX_W-1:0]   trial;
	logic [SMX_W-1:0]   diff;

	// remainder stays below the divisor, so the shifted value fits one word
	always_comb begin
		trial = {rem_q, num_q[SMX_D_W-1]};
		diff  = trial - div_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(SMX_D_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(SMX_D_W - 1)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SMX_D_W-2:0], 1'b0};
			if (trial >= div_q) begin
				rem_q <= diff[SMX_D_W-1:0];
			end else begin
				rem_q <= trial[SMX_D_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ sv/splitmix64_range_draw_core.sv @@
// SplitMix64 draw core: random bit, bounded integer by rejection, 53-bit unit fraction.
//
// Each draw advances the 64-bit seed by gamma and mixes it with the
// two-multiply finalizer; both multiplies run on one shared iterative 64x64 unit
// that forms three 32x32 partial products, one per cycle. A bounded integer
// adds a restoring remainder unit; a biased remainder forces a redraw, up to
// MaxTries tries, the last remainder used as is. A reversed range (high_bound
// below low_bound) and the unused kind make no draw, leave the seed alone, and
// show a zero result; bad_range flags the reversed range. The core takes one
// request at a time: the next request can transfer in the same cycle that the
// result is shown, and it is accepted while the last result still waits in the
// output register. A held result stalls the next one in its final state.
// Writing start_seed reloads the running seed; write configuration only while
// idle.
module splitmix64_range_draw_core import smx_pkg::*; #(
	parameter int MaxTries = SMX_MAX_TRIES
) (
	input  logic           clk,
	input  logic           arst_n,
	// request stream
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [127:0]   s_axis_tdata,  // [62:0] low_bound, [125:63] high_bound, zero pad
	input  logic [1:0]     s_axis_tuser,  // [1:0] kind
	// result stream
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [63:0]    m_axis_tdata,  // [62:0] draw_result, zero pad
	output logic [0:0]     m_axis_tuser,  // [0] bad_range
	// configuration writes
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [63:0]    cfg_data
);

	localparam int TryW = $clog2(MaxTries);

	smx_state_t         state_q;
	logic [SMX_W-1:0]   seed_q;
	logic [SMX_W-1:0]   gamma_q;
	logic [TryW-1:0]    tries_q;
	logic               out_valid_q;

	logic [1:0]         kind_q;
	logic [SMX_D_W-1:0] lo_q;
	logic [SMX_D_W-1:0] hi_q;
	logic [SMX_D_W-1:0] span_q;
	logic [SMX_D_W-1:0] draw_q;
	logic [SMX_D_W-1:0] res_q;
	logic               bad_q;
	logic [SMX_D_W-1:0] out_data_q;
	logic               out_bad_q;

	logic               in_xfer;
	logic               out_free;
	logic               mul_start;
	logic [SMX_W-1:0]   mul_a;
	logic [SMX_W-1:0]   mul_b;
	logic               mul_done;
	logic [SMX_W-1:0]   mul_p;
	logic [SMX_W-1:0]   draw;
	logic               div_start;
	logic [SMX_W-1:0]   modulus;
	logic               div_done;
	logic [SMX_D_W-1:0] div_rem;
	logic [SMX_D_W-1:0] unbiased;
	logic               take_ok;
	logic [SMX_D_W-1:0] in_range;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	// first multiply folds the fresh seed, the second folds the first product
	assign mul_start = (state_q == ST_M1GO) || (state_q == ST_M2GO);
	assign mul_a     = (state_q == ST_M1GO) ? smx_fold(seed_q) : smx_fold(mul_p);
	assign mul_b     = (state_q == ST_M1GO) ? SMX_MIX_C1 : SMX_MIX_C2;
	assign draw      = smx_fold(mul_p);

	assign div_start = (state_q == ST_DIVGO);
	assign modulus   = {1'b0, span_q} + {{(SMX_W-1){1'b0}}, 1'b1};

	// accept the try when d - r does not exceed MASK63 - span
	assign unbiased  = draw_q - div_rem;
	assign take_ok   = unbiased <= ~span_q;
	assign in_range  = lo_q + div_rem;

	smx_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (draw_q),
		.divisor  (modulus),
		.done     (div_done),
		.rem      (div_rem)
	);

	// sequencer, seed and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= '0;
			gamma_q     <= SMX_GAMMA_RESET;
			tries_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_START_SEED: seed_q  <= cfg_data;
					REG_GAMMA:      gamma_q <= cfg_data;
					default:        ;
				endcase
			end

			// drop the shown result once taken, unless a new one replaces it
			if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					tries_q <= '0;
					if (kind_q == KIND_BIT || kind_q == KIND_FRAC) begin
						state_q <= ST_ADV;
					end else if (kind_q == KIND_INT && !($signed(hi_q) < $signed(lo_q))) begin
						state_q <= ST_ADV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_ADV: begin
					seed_q  <= seed_q + gamma_q;
					state_q <= ST_M1GO;
				end
				ST_M1GO: state_q <= ST_M1WAIT;
				ST_M1WAIT: begin
					if (mul_done) begin
						state_q <= ST_M2GO;
					end
				end
				ST_M2GO: state_q <= ST_M2WAIT;
				ST_M2WAIT: begin
					if (mul_done) begin
						state_q <= (kind_q == KIND_INT) ? ST_DIVGO : ST_DONE;
					end
				end
				ST_DIVGO: state_q <= ST_DIVWAIT;
				ST_DIVWAIT: begin
					if (div_done) begin
						state_q <= ST_JUDGE;
					end
				end
				ST_JUDGE: begin
					// redraw on a biased remainder until the try budget runs out
					if (take_ok || tries_q == TryW'(MaxTries - 1)) begin
						state_q <= ST_DONE;
					end else begin
						tries_q <= tries_q + TryW'(1);
						state_q <= ST_ADV;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture, working values and result hold
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= s_axis_tuser;
			lo_q   <= s_axis_tdata[SMX_D_W-1:0];
			hi_q   <= s_axis_tdata[2*SMX_D_W-1:SMX_D_W];
		end
		if (state_q == ST_CHECK) begin
			span_q <= hi_q - lo_q;
			res_q  <= '0;
			bad_q  <= (kind_q == KIND_INT) && ($signed(hi_q) < $signed(lo_q));
		end
		if (state_q == ST_M2WAIT && mul_done) begin
			draw_q <= draw[SMX_D_W-1:0];
			if (kind_q == KIND_BIT) begin
				res_q <= {{(SMX_D_W-1){1'b0}}, draw[0]};
			end else begin
				res_q <= {{(SMX_D_W-(SMX_W-SMX_FRAC_SH)){1'b0}}, draw[SMX_W-1:SMX_FRAC_SH]};
			end
		end
		if (state_q == ST_JUDGE) begin
			res_q <= in_range;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= res_q;
			out_bad_q  <= bad_q;
		end
	end

	assign s_axis_tready   = (state_q == ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {1'b0, out_data_q};
	assign m_axis_tuser[0] = out_bad_q;

	// multiplier completes only while the sequencer waits for it
	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_M1WAIT || state_q == ST_M2WAIT))
		else $error("multiplier finished outside a wait state");

	// remainder unit completes only while the sequencer waits for it
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVWAIT)
		else $error("remainder unit finished outside its wait state");

	// a flagged range always carries a zero result
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '0)
		else $error("reversed range returned a nonzero result");

	// the seed moves only on a draw or a seed write
	a_seed_moves: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) != ST_ADV && !$past(cfg_valid)) |-> $stable(seed_q))
		else $error("seed changed without a draw or a seed write");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the SplitMix64 range draw core: bits, bounded integers, fractions.
module tb_top;
	import smx_pkg::*;

	localparam int      CLK_PERIOD       = 20;
	localparam int      RESET_CYCLES     = 4;
	localparam longint  TIMEOUT_CYCLES   = 3_000_000;
	localparam int      DRAIN_LIMIT      = 300_000;
	localparam int      TAIL_CYCLES      = 200;
	localparam int      LONG_HOLD_CYCLES = 500;
	localparam int      TRY_LIMIT        = 256;

	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam logic [63:0] GAMMA_AT_RESET = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A      = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_MUL_B      = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] MASK63         = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] HALF_SPAN      = 64'h4000_0000_0000_0000;

	// 63-bit signed bound extremes
	localparam logic [62:0] BOUND_MIN = 63'h4000_0000_0000_0000;
	localparam logic [62:0] BOUND_MAX = 63'h3fff_ffff_ffff_ffff;
	localparam logic [62:0] BOUND_NEG1 = '1;
	localparam longint      BOUND_MAX_L = 64'sh3fff_ffff_ffff_ffff;

	typedef struct packed {
		logic [62:0] value;
		logic        bad;
	} draw_rec_t;

	// DUT connections; every input starts at a known value
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_index = 1'b0;
	logic [63:0]  cfg_data = '0;

	// predictor state, mirrors the core's seed and gamma
	logic [63:0] model_seed = '0;
	logic [63:0] model_gamma = GAMMA_AT_RESET;
	draw_rec_t   pending_draws[$];
	draw_rec_t   due_draw;

	// traffic shaping knobs, percent of cycles spent idle
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_trig = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;

	// run statistics
	int n_requests = 0;
	int n_bounded = 0;
	int n_reversed = 0;
	int n_unused = 0;
	int n_checked = 0;
	int n_redraws = 0;
	int n_limit_hits = 0;
	int mismatch_count = 0;
	int drain_wait;

	splitmix64_range_draw_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // [62:0] low_bound, [125:63] high_bound, zero pad
		.s_axis_tuser (s_axis_tuser),   // [1:0] kind
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),   // [62:0] draw_result, zero pad
		.m_axis_tuser (m_axis_tuser),   // [0] bad_range
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop in case the core hangs or drops a handshake.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Two-multiply finalizer, all products wrap at 64 bits.
	function automatic logic [63:0] finalize64(input logic [63:0] z);
		logic [63:0] x;
		x = z ^ (z >> 33);
		x = x * MIX_MUL_A;
		x = x ^ (x >> 33);
		x = x * MIX_MUL_B;
		return x ^ (x >> 33);
	endfunction

	// Advance the model seed by gamma and return the mixed draw.
	function automatic logic [63:0] next_draw();
		model_seed = model_seed + model_gamma;
		return finalize64(model_seed);
	endfunction

	// Work out the result of one accepted request and queue it.
	task automatic predict_draw(input logic [1:0] kind, input logic [62:0] lo,
			input logic [62:0] hi);
		logic [63:0] z, lo64, hi64, span, modulus, d, r;
		int tries;
		draw_rec_t rec;
		rec = '0;
		n_requests++;
		case (kind)
			KIND_BIT: begin
				z = next_draw();
				rec.value = {62'd0, z[0]};
			end
			KIND_FRAC: begin
				z = next_draw();
				rec.value = 63'(z >> SMX_FRAC_SH);
			end
			KIND_INT: begin
				n_bounded++;
				lo64 = {lo[62], lo};
				hi64 = {hi[62], hi};
				if ($signed(hi64) < $signed(lo64)) begin
					// reversed range: no draw, seed untouched
					rec.bad = 1'b1;
					n_reversed++;
				end else begin
					span = hi64 - lo64;
					modulus = span + 64'd1;
					r = '0;
					for (tries = 0; tries < TRY_LIMIT; tries++) begin
						d = next_draw() & MASK63;
						r = d % modulus;
						if (d - r <= MASK63 - span)
							break;
					end
					// tries counts the rejected draws; all of them at the limit
					n_redraws += tries;
					if (tries == TRY_LIMIT)
						n_limit_hits++;
					rec.value = 63'(lo64 + r);
				end
			end
			default: begin
				// unused kind: zero result, no draw
				n_unused++;
			end
		endcase
		pending_draws.push_back(rec);
	endtask

	// ------------------------------------------------------------------
	// Driving helpers
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Offer one request after a random gap; return at the edge it transfers.
	task automatic send_item(input logic [1:0] kind, input logic [62:0] lo,
			input logic [62:0] hi);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, hi, lo};
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_draw(kind, lo, hi);
	endtask

	// Stop offering and hold until every predicted result has been taken.
	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_draws.size() != 0);
	endtask

	// Write one register; call only with the core idle.
	task automatic cfg_write(input logic idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_START_SEED)
			model_seed = value;
		else
			model_gamma = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Pick bounds: mostly narrow ranges, some wide ones that often reject,
	// some fully random or reversed ones.
	function automatic void pick_bounds(output logic [62:0] lo, output logic [62:0] hi);
		longint l, h, t;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode <= 4) begin
			l = $signed(63'(rand64()));
			if ($urandom_range(0, 3) == 0)
				h = l + longint'($urandom);
			else
				h = l + longint'($urandom_range(0, 1000));
			if (h > BOUND_MAX_L)
				h = BOUND_MAX_L;
		end else if (mode <= 6) begin
			l = $signed({1'b1, 62'(rand64())});
			h = $signed({1'b0, 62'(rand64())});
		end else if (mode == 7) begin
			l = $signed(63'(rand64()));
			h = $signed(63'(rand64()));
		end else if (mode == 8) begin
			l = $signed(63'(rand64()));
			h = $signed(63'(rand64()));
			if (h > l) begin
				t = l;
				l = h;
				h = t;
			end
		end else begin
			l = longint'($urandom_range(0, 20)) - 10;
			h = l + longint'($urandom_range(0, 3));
		end
		lo = l[62:0];
		hi = h[62:0];
	endfunction

	task automatic random_item();
		logic [62:0] lo, hi;
		int pick;
		pick = $urandom_range(0, 99);
		pick_bounds(lo, hi);
		if (pick < 20)
			send_item(KIND_BIT, lo, hi);
		else if (pick < 40)
			send_item(KIND_FRAC, lo, hi);
		else if (pick < 95)
			send_item(KIND_INT, lo, hi);
		else
			send_item(KIND_UNUSED, lo, hi);
	endtask

	// Seed whose draw with zero gamma lands in the biased tail of span 2^62,
	// so every try is rejected.
	function automatic logic [63:0] find_stuck_seed();
		logic [63:0] s;
		s = 64'd1;
		while ((finalize64(s) & MASK63) <= HALF_SPAN)
			s++;
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold on request, field checks
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_draws.size() == 0) begin
				report_mismatch($sformatf("result %h/%b with nothing expected",
					m_axis_tdata[62:0], m_axis_tuser[0]));
			end else begin
				due_draw = pending_draws.pop_front();
				n_checked++;
				if (m_axis_tdata[62:0] !== due_draw.value)
					report_mismatch($sformatf("result %0d: draw_result %h, expected %h",
						n_checked, m_axis_tdata[62:0], due_draw.value));
				if (m_axis_tuser[0] !== due_draw.bad)
					report_mismatch($sformatf("result %0d: bad_range %b, expected %b",
						n_checked, m_axis_tuser[0], due_draw.bad));
			end
		end
		// a toggle of hold_trig starts one long hold, counted down here
		if (hold_trig != hold_seen) begin
			hold_seen = hold_trig;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Draw with the reset seed and gamma, no register written.
	task automatic test_reset_defaults();
		send_item(KIND_FRAC, '0, '0);
		send_item(KIND_BIT, '0, '0);
		send_item(KIND_INT, 63'h7fff_ffff_ffff_ff9c, 63'd100);
	endtask

	// Extreme seeds and gammas, extreme and reversed bounds, unused kind.
	task automatic test_range_edges();
		wait_results_done();
		cfg_write(REG_START_SEED, '1);
		cfg_write(REG_GAMMA, '1);
		send_item(KIND_BIT, '1, '1);
		send_item(KIND_FRAC, '1, '1);
		send_item(KIND_INT, BOUND_MIN, BOUND_MAX);   // widest range
		send_item(KIND_INT, BOUND_MIN, BOUND_MIN);   // single value at the bottom
		send_item(KIND_INT, BOUND_MAX, BOUND_MAX);   // single value at the top
		send_item(KIND_INT, BOUND_MAX, BOUND_MIN);   // reversed, widest
		send_item(KIND_INT, '0, BOUND_NEG1);         // reversed by one
		send_item(KIND_INT, BOUND_NEG1, '0);
		send_item(KIND_UNUSED, '1, '1);
		send_item(KIND_UNUSED, '0, '0);
		wait_results_done();
		cfg_write(REG_START_SEED, '0);
		cfg_write(REG_GAMMA, 64'd1);
		send_item(KIND_BIT, '0, '0);
		send_item(KIND_FRAC, '0, '0);
		send_item(KIND_INT, '0, 63'd1);
		send_item(KIND_INT, BOUND_MIN, '0);          // span 2^62, rejects often
	endtask

	// Zero gamma repeats the same draw: a biased one runs out of tries.
	task automatic test_retry_limit();
		wait_results_done();
		cfg_write(REG_GAMMA, '0);
		cfg_write(REG_START_SEED, find_stuck_seed());
		send_item(KIND_INT, BOUND_MIN, '0);
		send_item(KIND_BIT, '0, '0);
		send_item(KIND_INT, 63'h7fff_ffff_ffff_fffb, 63'd5);
	endtask

	// Random traffic under one idle pattern, with fresh seed and gamma.
	task automatic test_random_traffic(input int idle_pct, input int rcv_pct, input int count);
		int i;
		logic [63:0] g;
		wait_results_done();
		send_idle_pct = idle_pct;
		stall_pct = rcv_pct;
		g = rand64();
		if ($urandom_range(0, 3) != 0)
			g[0] = 1'b1;
		cfg_write(REG_GAMMA, g);
		cfg_write(REG_START_SEED, rand64());
		for (i = 0; i < count; i++)
			random_item();
	endtask

	// Long output hold while requests keep coming, then a full pause of the sender.
	task automatic test_output_stall();
		int i;
		send_idle_pct = 10;
		stall_pct = 0;
		hold_trig = ~hold_trig;
		for (i = 0; i < 12; i++)
			random_item();
		wait_results_done();
		for (i = 0; i < 12; i++)
			random_item();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_range_edges();
		test_retry_limit();
		test_random_traffic(37, 45, 140);
		test_random_traffic(45, 37, 140);
		test_random_traffic(0, 0, 140);
		test_output_stall();

		// drain, then give stray results a chance to show up
		s_axis_tvalid <= 1'b0;
		drain_wait = 0;
		while (pending_draws.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		if (pending_draws.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_draws.size()));
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d bounded, %0d reversed, %0d unused kind), checked %0d",
			n_requests, n_bounded, n_reversed, n_unused, n_checked);
		$display("Rejected draws redone: %0d, requests out of tries: %0d, mismatches: %0d",
			n_redraws, n_limit_hits, mismatch_count);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
sv/smx_pkg.sv
sv/smx_mul.sv
sv/smx_div.sv
sv/splitmix64_range_draw_core.sv
dv/tb_top.sv
